@@ hdl/bcm_pkg.sv @@
// bcm_pkg: shared widths, prime constants and controller/datapath command types
// for the binomial coefficient mod prime block; no dependencies
`default_nettype none

package bcm_pkg;

  localparam int N_W    = 11;           // width of n and k
  localparam int RES_W  = 30;           // width of a residue mod the prime
  localparam int PROD_W = 2 * RES_W;    // full product of two residues
  localparam int MU_W   = RES_W + 1;    // barrett reciprocal width
  localparam int Q2_W   = 2 * MU_W;     // quotient estimate product width

  localparam logic [RES_W-1:0] PRIME    = 30'd1000000007;
  localparam logic [RES_W-1:0] PRIME_M2 = PRIME - 30'd2;

  // floor(2^60 / p) for barrett reduction of products below 2^60
  localparam logic [MU_W-1:0] BARRETT_MU =
    MU_W'(({1'b1, {PROD_W{1'b0}}}) / (PROD_W + 1)'(PRIME));

  localparam int EXP_BIT_W = 5;
  localparam logic [EXP_BIT_W-1:0] EXP_TOP = 5'd29;  // top set bit of p-2

  typedef enum logic [2:0] {
    MM_FACT,
    MM_DENOM,
    MM_SQUARE,
    MM_MULBASE,
    MM_FINAL
  } mm_op_t;

  typedef struct packed {
    logic   load;
    logic   mm_start;
    mm_op_t mm_op;
    logic   out_load;
  } bcm_cmd_t;

  typedef struct packed {
    logic mm_done;
    logic i_eq_n;
    logic range_err;
  } bcm_status_t;

endpackage

`default_nettype wire

@@ hdl/bcm_if.sv @@
// bcm_if: valid/ready channel interfaces for the input pair and the result word
// depends on bcm_pkg for field widths
`default_nettype none

interface bcm_in_if;
  logic                      valid;
  logic                      ready;
  logic [bcm_pkg::N_W-1:0]   total_count;
  logic [bcm_pkg::N_W-1:0]   choose_count;

  modport source (output valid, output total_count, output choose_count, input ready);
  modport sink   (input valid, input total_count, input choose_count, output ready);
endinterface

interface bcm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bcm_pkg::RES_W-1:0] binomial_mod;
  logic                      range_error;

  modport source (output valid, output binomial_mod, output range_error, input ready);
  modport sink   (input valid, input binomial_mod, input range_error, output ready);
endinterface

`default_nettype wire

@@ hdl/bcm_modmul.sv @@
// bcm_modmul: pipelined modular multiplier, a*b mod p by barrett reduction
// depends on bcm_pkg for the prime and the reciprocal
`default_nettype none

module bcm_modmul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bcm_pkg::RES_W-1:0] a,
  input  wire logic [bcm_pkg::RES_W-1:0] b,
  output logic                           done,
  output logic [bcm_pkg::RES_W-1:0]      result
);

  localparam int RW  = bcm_pkg::RES_W;
  localparam int PW  = bcm_pkg::PROD_W;
  localparam int MW  = bcm_pkg::MU_W;
  localparam int QW  = bcm_pkg::Q2_W;
  localparam int QPW = MW + RW;
  localparam logic [31:0] P1 = 32'(bcm_pkg::PRIME);
  localparam logic [31:0] P2 = P1 << 1;

  logic [PW-1:0]  prod_r;
  logic [QW-1:0]  q2_r;
  logic [31:0]    qp_r;
  logic [RW-1:0]  res_r;
  logic [3:0]     v_r;

  logic [QPW-1:0] qp_full;
  logic [31:0]    rem;
  logic [31:0]    rem_m1;
  logic [31:0]    rem_m2;
  logic [31:0]    rem_sel;

  // only the low 32 bits matter: the true remainder is below 3p < 2^32
  assign qp_full = QPW'(q2_r[QW-1:MW]) * QPW'(bcm_pkg::PRIME);
  assign rem     = prod_r[31:0] - qp_r;
  assign rem_m1  = rem - P1;
  assign rem_m2  = rem - P2;

  always_comb begin
    if (rem >= P2) begin
      rem_sel = rem_m2;
    end else if (rem >= P1) begin
      rem_sel = rem_m1;
    end else begin
      rem_sel = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
    if (start) begin
      prod_r <= PW'(a) * PW'(b);
    end
    if (v_r[0]) begin
      q2_r <= QW'(prod_r[PW-1:RW-1]) * QW'(bcm_pkg::BARRETT_MU);
    end
    if (v_r[1]) begin
      qp_r <= qp_full[31:0];
    end
    if (v_r[2]) begin
      res_r <= rem_sel[RW-1:0];
    end
  end

  assign done   = v_r[3];
  assign result = res_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (v_r[2:0] == 3'b000))
    else $error("modmul started while a product is in flight");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (res_r < bcm_pkg::PRIME))
    else $error("modmul result not fully reduced");

endmodule

`default_nettype wire

@@ hdl/bcm_datapath.sv @@
// bcm_datapath: operand registers, factorial counter, shared modular multiplier
// and result word register; depends on bcm_pkg and bcm_modmul
`default_nettype none

module bcm_datapath #(
  parameter int MAX_N = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [bcm_pkg::N_W-1:0]   in_total_count,
  input  wire logic [bcm_pkg::N_W-1:0]   in_choose_count,
  input  wire bcm_pkg::bcm_cmd_t         cmd,
  output bcm_pkg::bcm_status_t           status,
  output logic [bcm_pkg::RES_W-1:0]      out_binomial_mod,
  output logic                           out_range_error
);

  localparam int NW = bcm_pkg::N_W;
  localparam int RW = bcm_pkg::RES_W;

  logic [NW-1:0]    n_r, k_r, nk_r, i_r;
  logic             err_r;
  logic [RW-1:0]    acc_r, fk_r, fnk_r, base_r, pow_r;
  bcm_pkg::mm_op_t  op_r;
  logic [RW-1:0]    out_mod_r;
  logic             out_err_r;

  logic             mm_done;
  logic [RW-1:0]    mm_res;
  logic [RW-1:0]    mm_a, mm_b;
  logic             wr_acc, wr_fk, wr_fnk, wr_base, wr_pow;
  logic [RW-1:0]    acc_cur, fk_cur, fnk_cur, base_cur, pow_cur;
  logic [NW-1:0]    i_inc;
  logic             load_err;

  assign load_err = (in_choose_count > in_total_count) ||
                    (32'(in_total_count) > 32'(MAX_N));

  // write-back of the finishing product, forwarded to the next operand mux
  assign wr_acc  = mm_done && (op_r == bcm_pkg::MM_FACT);
  assign wr_fk   = wr_acc && (i_r == k_r);
  assign wr_fnk  = wr_acc && (i_r == nk_r);
  assign wr_base = mm_done && (op_r == bcm_pkg::MM_DENOM);
  assign wr_pow  = mm_done && ((op_r == bcm_pkg::MM_DENOM) ||
                               (op_r == bcm_pkg::MM_SQUARE) ||
                               (op_r == bcm_pkg::MM_MULBASE));

  assign acc_cur  = wr_acc  ? mm_res : acc_r;
  assign fk_cur   = wr_fk   ? mm_res : fk_r;
  assign fnk_cur  = wr_fnk  ? mm_res : fnk_r;
  assign base_cur = wr_base ? mm_res : base_r;
  assign pow_cur  = wr_pow  ? mm_res : pow_r;
  assign i_inc    = i_r + NW'(1);

  always_comb begin
    case (cmd.mm_op)
      bcm_pkg::MM_FACT: begin
        mm_a = acc_cur;
        mm_b = RW'(i_inc);
      end
      bcm_pkg::MM_DENOM: begin
        mm_a = fk_cur;
        mm_b = fnk_cur;
      end
      bcm_pkg::MM_SQUARE: begin
        mm_a = pow_cur;
        mm_b = pow_cur;
      end
      bcm_pkg::MM_MULBASE: begin
        mm_a = pow_cur;
        mm_b = base_cur;
      end
      bcm_pkg::MM_FINAL: begin
        mm_a = acc_cur;
        mm_b = pow_cur;
      end
      default: begin
        mm_a = acc_cur;
        mm_b = pow_cur;
      end
    endcase
  end

  bcm_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .done   (mm_done),
    .result (mm_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= in_total_count;
      k_r   <= in_choose_count;
      nk_r  <= in_total_count - in_choose_count;
      err_r <= load_err;
      i_r   <= '0;
      acc_r <= RW'(1);
      fk_r  <= RW'(1);
      fnk_r <= RW'(1);
    end else begin
      if (cmd.mm_start && (cmd.mm_op == bcm_pkg::MM_FACT)) begin
        i_r <= i_inc;
      end
      if (wr_acc) begin
        acc_r <= mm_res;
      end
      if (wr_fk) begin
        fk_r <= mm_res;
      end
      if (wr_fnk) begin
        fnk_r <= mm_res;
      end
    end
    if (wr_base) begin
      base_r <= mm_res;
    end
    if (wr_pow) begin
      pow_r <= mm_res;
    end
    if (cmd.mm_start) begin
      op_r <= cmd.mm_op;
    end
    if (cmd.out_load) begin
      out_mod_r <= err_r ? '0 : mm_res;
      out_err_r <= err_r;
    end
  end

  assign status.mm_done   = mm_done;
  assign status.i_eq_n    = (i_r == n_r);
  assign status.range_err = err_r;

  assign out_binomial_mod = out_mod_r;
  assign out_range_error  = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (!out_err_r || (out_mod_r == '0)))
    else $error("flagged word carries a nonzero value");

endmodule

`default_nettype wire

@@ hdl/bcm_ctrl.sv @@
// bcm_ctrl: sequencer for factorial, fermat inversion and output handshake
// depends on bcm_pkg for command and status types
`default_nettype none

module bcm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire bcm_pkg::bcm_status_t  status,
  output bcm_pkg::bcm_cmd_t          cmd
);

  localparam int EW = bcm_pkg::EXP_BIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FACT,
    S_DENOM,
    S_SQR,
    S_MULB,
    S_FIN,
    S_DRAIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [EW-1:0] bit_r, bit_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mm_op     = bcm_pkg::MM_FACT;
    in_ready      = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK, S_FACT: begin
        if (state_r == S_CHECK && status.range_err) begin
          state_nxt = S_DRAIN;
        end else if (state_r == S_CHECK || status.mm_done) begin
          cmd.mm_start = 1'b1;
          if (status.i_eq_n) begin
            cmd.mm_op = bcm_pkg::MM_DENOM;
            state_nxt = S_DENOM;
          end else begin
            cmd.mm_op = bcm_pkg::MM_FACT;
            state_nxt = S_FACT;
          end
        end
      end
      S_DENOM: begin
        // pow starts at the base, which covers the top exponent bit
        if (status.mm_done) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = bcm_pkg::MM_SQUARE;
          bit_nxt      = bcm_pkg::EXP_TOP - EW'(1);
          state_nxt    = S_SQR;
        end
      end
      S_SQR: begin
        if (status.mm_done) begin
          cmd.mm_start = 1'b1;
          if (bcm_pkg::PRIME_M2[bit_r]) begin
            cmd.mm_op = bcm_pkg::MM_MULBASE;
            state_nxt = S_MULB;
          end else if (bit_r == '0) begin
            cmd.mm_op = bcm_pkg::MM_FINAL;
            state_nxt = S_FIN;
          end else begin
            cmd.mm_op = bcm_pkg::MM_SQUARE;
            bit_nxt   = bit_r - EW'(1);
          end
        end
      end
      S_MULB: begin
        if (status.mm_done) begin
          cmd.mm_start = 1'b1;
          if (bit_r == '0) begin
            cmd.mm_op = bcm_pkg::MM_FINAL;
            state_nxt = S_FIN;
          end else begin
            cmd.mm_op = bcm_pkg::MM_SQUARE;
            bit_nxt   = bit_r - EW'(1);
            state_nxt = S_SQR;
          end
        end
      end
      S_FIN: begin
        if (status.mm_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result word overwritten before it was taken");

  a_start_gated: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mm_start |-> ((state_r == S_CHECK) || status.mm_done))
    else $error("multiply issued while the multiplier is busy");

endmodule

`default_nettype wire

@@ hdl/binomial_coefficient_mod_prime.sv @@
// binomial_coefficient_mod_prime: top level joining controller and datapath
// depends on bcm_pkg, bcm_if, bcm_ctrl, bcm_datapath
`default_nettype none

// Computes C(n,k) mod 1000000007 for one (n, k) word at a time. n! is built by
// n dependent modular multiplies while k! and (n-k)! are captured on the way,
// their product is inverted by square-and-multiply to the power p-2 (29
// squarings and 14 multiplies), and a last multiply gives the answer. All work
// runs on one shared Barrett multiplier, one product at a time, so an item
// takes n + 45 multiplies before its result word is loaded into the output
// register; an out-of-range pair (k > n or n > MAX_N) skips the multiplies and
// answers 0 with range_error set. A new word is accepted while the previous
// result still waits in the output register.
module binomial_coefficient_mod_prime #(
  parameter int MAX_N = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bcm_in_if.sink     in_ch,
  bcm_out_if.source  out_ch
);

  bcm_pkg::bcm_cmd_t    cmd;
  bcm_pkg::bcm_status_t status;

  bcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcm_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_total_count   (in_ch.total_count),
    .in_choose_count  (in_ch.choose_count),
    .cmd              (cmd),
    .status           (status),
    .out_binomial_mod (out_ch.binomial_mod),
    .out_range_error  (out_ch.range_error)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for binomial_coefficient_mod_prime, table of directed words then
// random words, each result checked against its typed table value or a local C(n,k) mod p predictor
// depends on bcm_pkg, bcm_if and the binomial_coefficient_mod_prime top level
module tb;

  localparam int RES_W          = bcm_pkg::RES_W;
  localparam int N_W            = bcm_pkg::N_W;
  localparam int MAX_N          = 1024;
  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_WORDS   = 122;
  localparam int DRAIN_EVERY    = 35;
  localparam int WATCHDOG_LIMIT = 20000;  // several times the slowest word plus stalls
  localparam int SETTLE_CYCLES  = 4400;   // about one full-size word

  typedef struct packed {
    logic [RES_W-1:0] binomial_mod;
    logic             range_error;
  } binom_word_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;
    logic           typed;
    binom_word_t    fixed;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  bcm_in_if  in_ch ();
  bcm_out_if out_ch ();

  binomial_coefficient_mod_prime #(.MAX_N(MAX_N)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [RES_W-1:0] fact_mod [0:MAX_N];
  binom_word_t      pending_q [$];
  stim_row_t        directed_rows [18];

  // typed expectation riding along with the word on the input channel
  logic        row_typed;
  binom_word_t row_fixed;

  int error_count   = 0;
  int words_in      = 0;
  int flagged_in    = 0;
  int largest_n     = 0;
  int quiet_cycles  = 0;
  int burst_left    = 0;
  int rx_phase_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  function automatic logic [RES_W-1:0] mul_mod(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    longint unsigned prod;
    prod = 64'(a) * 64'(b);
    return RES_W'(prod % 64'(bcm_pkg::PRIME));
  endfunction

  function automatic logic [RES_W-1:0] pow_mod(logic [RES_W-1:0] base,
                                               logic [RES_W-1:0] e);
    logic [RES_W-1:0] acc;
    logic [RES_W-1:0] sq;
    acc = RES_W'(1);
    sq  = base;
    for (int b = 0; b < RES_W; b++) begin
      if (e[b]) acc = mul_mod(acc, sq);
      sq = mul_mod(sq, sq);
    end
    return acc;
  endfunction

  function automatic binom_word_t binomial_of(logic [N_W-1:0] n, logic [N_W-1:0] k);
    binom_word_t r;
    logic [RES_W-1:0] denom;
    r.binomial_mod = '0;
    r.range_error  = 1'b1;
    if (k <= n && n <= MAX_N) begin
      denom          = mul_mod(fact_mod[k], fact_mod[n - k]);
      r.binomial_mod = mul_mod(fact_mod[n], pow_mod(denom, bcm_pkg::PRIME_M2));
      r.range_error  = 1'b0;
    end
    return r;
  endfunction

  // receiver: long open stretches, random stalls and short hard stalls
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 2));
      rx_phase_left = (rx_mode == RX_OPEN) ? $urandom_range(50, 400) : $urandom_range(1, 20);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
      default:   out_ch.ready <= 1'b0;
    endcase
  end

  // input and result handshakes, scoreboard and watchdog in one place
  always @(posedge clk) begin
    binom_word_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = row_typed ? row_fixed : binomial_of(in_ch.total_count, in_ch.choose_count);
        pending_q = {pending_q, want};
        words_in++;
        if (want.range_error) flagged_in++;
        else if (int'(in_ch.total_count) > largest_n) largest_n = int'(in_ch.total_count);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("result word with nothing pending: binomial_mod %0d range_error %0d",
                 out_ch.binomial_mod, out_ch.range_error);
          error_count++;
        end else begin
          want = pending_q.pop_front();
          if (out_ch.binomial_mod !== want.binomial_mod) begin
            $error("binomial_mod: expected %0d, got %0d", want.binomial_mod,
                   out_ch.binomial_mod);
            error_count++;
          end
          if (out_ch.range_error !== want.range_error) begin
            $error("range_error: expected %0d, got %0d", want.range_error,
                   out_ch.range_error);
            error_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 quiet_cycles, pending_q.size());
        $display("binomial_coefficient_mod_prime regression: fail");
        $finish;
      end
    end
  end

  // valid stays up across a burst; a gap drops it for a random number of cycles
  task automatic send_word(input logic [N_W-1:0] n, input logic [N_W-1:0] k,
                           input logic typed, input binom_word_t fixed);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600)
                                                : $urandom_range(1, 30);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.total_count  <= n;
    in_ch.choose_count <= k;
    row_typed          <= typed;
    row_fixed          <= fixed;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  initial begin
    int pick;
    int n;
    int k;
    in_ch.valid        = 1'b0;
    in_ch.total_count  = '0;
    in_ch.choose_count = '0;
    row_typed          = 1'b0;
    row_fixed          = '0;
    rst_n              = 1'b0;

    fact_mod[0] = RES_W'(1);
    for (int i = 1; i <= MAX_N; i++) fact_mod[i] = mul_mod(fact_mod[i-1], RES_W'(i));

    // n, k, typed, {binomial_mod, range_error}
    directed_rows = '{
      '{11'd0,    11'd0,    1'b1, '{30'd1,    1'b0}},
      '{11'd1,    11'd0,    1'b1, '{30'd1,    1'b0}},
      '{11'd1,    11'd1,    1'b1, '{30'd1,    1'b0}},
      '{11'd1024, 11'd0,    1'b1, '{30'd1,    1'b0}},
      '{11'd1024, 11'd1024, 1'b1, '{30'd1,    1'b0}},
      '{11'd1024, 11'd1,    1'b1, '{30'd1024, 1'b0}},
      '{11'd1024, 11'd1023, 1'b1, '{30'd1024, 1'b0}},
      '{11'd7,    11'd8,    1'b1, '{30'd0,    1'b1}},
      '{11'd0,    11'd2047, 1'b1, '{30'd0,    1'b1}},
      '{11'd1024, 11'd1025, 1'b1, '{30'd0,    1'b1}},
      '{11'd1025, 11'd0,    1'b1, '{30'd0,    1'b1}},
      '{11'd2047, 11'd2047, 1'b1, '{30'd0,    1'b1}},
      '{11'd1365, 11'd682,  1'b1, '{30'd0,    1'b1}},
      '{11'd682,  11'd1365, 1'b1, '{30'd0,    1'b1}},
      '{11'd10,   11'd3,    1'b0, '{30'd0,    1'b0}},
      '{11'd100,  11'd50,   1'b0, '{30'd0,    1'b0}},
      '{11'd1024, 11'd512,  1'b0, '{30'd0,    1'b0}},
      '{11'd1023, 11'd511,  1'b0, '{30'd0,    1'b0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].n, directed_rows[i].k, directed_rows[i].typed,
                directed_rows[i].fixed);
    wait_all_results();

    // mostly small n, some medium, a few at full size, the rest out of range
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 63);
        k = $urandom_range(0, n);
      end else if (pick < 72) begin
        n = $urandom_range(64, 400);
        k = $urandom_range(0, n);
      end else if (pick < 77) begin
        n = $urandom_range(1000, MAX_N);
        k = $urandom_range(0, n);
      end else if (pick < 87) begin
        n = $urandom_range(0, 1023);
        k = $urandom_range(n + 1, 2047);
      end else begin
        n = $urandom_range(MAX_N + 1, 2047);
        k = $urandom_range(0, 2047);
      end
      send_word(N_W'(n), N_W'(k), 1'b0, '0);
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_all_results();
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("checked %0d words: %0d flagged out of range, largest in-range n %0d",
             words_in, flagged_in, largest_n);
    $display("sender ran in bursts with gaps, receiver mixed open, random and held stalls");
    if (error_count == 0) begin
      $display("binomial_coefficient_mod_prime regression: pass");
    end else begin
      $display("binomial_coefficient_mod_prime regression: fail");
    end
    $finish;
  end

endmodule
